FILE: sv/centroid_track_matcher_top_defines.svh
// Assertion macros shared by the tracker RTL.
`ifndef CENTROID_TRACK_MATCHER_TOP_DEFINES_SVH
`define CENTROID_TRACK_MATCHER_TOP_DEFINES_SVH

// Implication checked every clock edge outside reset.
`define CTM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define CTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: sv/ctm_pkg.sv
`default_nettype none
package ctm_pkg;
   localparam int MaxTracks = 16;
   localparam int SlotW = $clog2(MaxTracks);
   localparam int CntW = $clog2(MaxTracks + 1);

   localparam logic [1:0] CMD_DETECT = 2'd0;
   localparam logic [1:0] CMD_EOF = 2'd1;
   localparam logic [1:0] CMD_RESET = 2'd2;

   localparam logic [1:0] CSR_MAX_LOST = 2'd0;
   localparam logic [1:0] CSR_MAX_DIST = 2'd1;
   localparam logic [1:0] CSR_MIN_FOUND = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_AGE,
      ST_REPORT,
      ST_EMPTY
   } state_type;

   // Slot record held in each cell.
   typedef struct packed {
      logic        used;
      logic        fresh;
      logic        matched;
      logic [15:0] id;
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  lost;
      logic [7:0]  found;
   } slot_type;

   // Control word from the sequencer to every cell.
   typedef struct packed {
      logic        rotate;  // shift the ring one position
      logic        clear;   // empty all slots
      logic        age;     // age the slot at the head
      logic        upd;     // write the head slot as matched
      logic        open;    // write the head slot as a new track
      logic [11:0] x;
      logic [11:0] y;
      logic [15:0] id;
      logic [7:0]  lost_limit;
      logic [7:0]  found_cap;
   } cell_ctl_type;
endpackage
`default_nettype wire

FILE: sv/ctm_cell.sv
`default_nettype none
// One slot of the ring. The head cell (fed by the tail) applies updates.
module ctm_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  is_head,
   input  wire ctm_pkg::cell_ctl_type ctl,
   input  wire ctm_pkg::slot_type     slot_prev,
   output ctm_pkg::slot_type          slot_out
);
   ctm_pkg::slot_type slot_ff, slot_in, base;
   logic [8:0] lost_inc;
   logic [8:0] found_inc;

   always_comb begin
      base = ctl.rotate ? slot_prev : slot_ff;
      slot_in = base;
      lost_inc = {1'b0, base.lost} + 9'd1;
      found_inc = {1'b0, base.found} + 9'd1;
      if (ctl.clear) begin
         slot_in.used = 1'b0;
         slot_in.fresh = 1'b0;
         slot_in.matched = 1'b0;
      end else if (is_head) begin
         if (ctl.upd) begin
            slot_in.x = ctl.x;
            slot_in.y = ctl.y;
            slot_in.lost = '0;
            slot_in.found = (found_inc < {1'b0, ctl.found_cap}) ? found_inc[7:0]
                                                                 : ctl.found_cap;
            slot_in.matched = 1'b1;
         end else if (ctl.open) begin
            slot_in.used = 1'b1;
            slot_in.fresh = 1'b1;
            slot_in.matched = 1'b0;
            slot_in.id = ctl.id;
            slot_in.x = ctl.x;
            slot_in.y = ctl.y;
            slot_in.lost = '0;
            slot_in.found = '0;
         end else if (ctl.age && base.used) begin
            if (!base.fresh && !base.matched) begin
               if (lost_inc >= {1'b0, ctl.lost_limit}) slot_in.used = 1'b0;
               else slot_in.lost = lost_inc[7:0];
            end
            slot_in.fresh = 1'b0;
            slot_in.matched = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.used <= 1'b0;
         slot_ff.fresh <= 1'b0;
         slot_ff.matched <= 1'b0;
      end else begin
         slot_ff.used <= slot_in.used;
         slot_ff.fresh <= slot_in.fresh;
         slot_ff.matched <= slot_in.matched;
      end
      slot_ff.id <= slot_in.id;
      slot_ff.x <= slot_in.x;
      slot_ff.y <= slot_in.y;
      slot_ff.lost <= slot_in.lost;
      slot_ff.found <= slot_in.found;
   end

   assign slot_out = slot_ff;
endmodule
`default_nettype wire

FILE: sv/ctm_dist.sv
`default_nettype none
// Registered squared distance of the detection to the slot at the ring head.
module ctm_dist (
   input  wire logic        clock,
   input  wire logic [11:0] x_pos,
   input  wire logic [11:0] y_pos,
   input  wire logic [11:0] slot_x,
   input  wire logic [11:0] slot_y,
   output logic [24:0]      dist_sq
);
   logic [11:0] dx_ff, dy_ff;
   logic [11:0] dx_in, dy_in;
   logic [23:0] dx_sq, dy_sq;
   logic [24:0] dist_ff, dist_in;

   always_comb begin
      dx_in = (x_pos >= slot_x) ? x_pos - slot_x : slot_x - x_pos;
      dy_in = (y_pos >= slot_y) ? y_pos - slot_y : slot_y - y_pos;
      dx_sq = dx_ff * dx_ff;
      dy_sq = dy_ff * dy_ff;
      dist_in = {1'b0, dx_sq} + {1'b0, dy_sq};
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dist_ff <= dist_in;
   end

   assign dist_sq = dist_ff;
endmodule
`default_nettype wire

FILE: sv/centroid_track_matcher_top.sv
// Detection: accept, a ring turn plus the distance pipeline to score, a ring turn to
// write back.
// End of frame: accept, a ring turn to age, a ring turn to report, and one empty word
// when nothing is confirmed; a stalled word holds the walk.
// Reset and unused commands finish in the accepting state. Throughput one item at a time.
// Reset: synchronous, active high; empties the table, clears id, overflow, register defaults.
`default_nettype none
`include "centroid_track_matcher_top_defines.svh"
module centroid_track_matcher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [11:0] req_x_pos,
   input  wire logic [11:0] req_y_pos,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_has_track,
   output logic [15:0]      rsp_track_id,
   output logic [11:0]      rsp_track_x,
   output logic [11:0]      rsp_track_y,
   output logic [7:0]       rsp_lost_count,
   output logic [7:0]       rsp_found_count,
   output logic             rsp_table_overflow,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);
   localparam int N = ctm_pkg::MaxTracks;
   localparam int SW = ctm_pkg::SlotW;
   localparam int CW = ctm_pkg::CntW;

   ctm_pkg::state_type state_ff, state_in;
   ctm_pkg::slot_type slots [N];
   ctm_pkg::cell_ctl_type ctl;

   logic [7:0]  max_lost_ff;
   logic [11:0] max_dist_ff;
   logic [7:0]  min_found_ff;
   logic [23:0] radius_sq;
   logic [15:0] next_id_ff, next_id_in;
   logic        ovf_ff, ovf_in;
   logic [11:0] x_ff, x_in, y_ff, y_in;
   logic [CW:0] cnt_ff, cnt_in;           // ring steps taken
   logic [SW:0] pos_ff, pos_in;           // ring offset, also scan index
   logic [24:0] best_ff, best_in;
   logic [SW:0] pick_ff, pick_in;         // bit SW set means none
   logic [SW:0] free_ff, free_in;
   logic        found_any_ff, found_any_in;
   logic [CW-1:0] rep_ff, rep_in;
   logic [24:0] dist_sq;
   logic [SW:0] score_pos;
   logic        rsp_valid_ff;
   ctm_pkg::slot_type out_ff;
   logic        out_has_ff, out_ovf_ff, out_last_ff;
   ctm_pkg::slot_type head, report_slot;
   logic        report_hit, rest_hit;
   logic        out_free;
   logic        load_hit, load_empty;
   logic [1:0]  elig_pipe_ff;
   logic        elig_now;

   // Cell g holds slot (g + pos_ff) mod N, so cell 0 shows slot pos_ff.
   assign head = slots[0];
   assign report_slot = head;
   assign report_hit = report_slot.used && (report_slot.found >= min_found_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign radius_sq = max_dist_ff * max_dist_ff;
   assign elig_now = head.used && !head.fresh && !head.matched;
   assign load_hit = (state_ff == ctm_pkg::ST_REPORT) && out_free && report_hit;
   assign load_empty = (state_ff == ctm_pkg::ST_EMPTY) && out_free;

   for (genvar g = 0; g < N; g++) begin : g_cell
      ctm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .is_head  (g == N - 1),
         .ctl      (ctl),
         .slot_prev(slots[(g + 1) % N]),
         .slot_out (slots[g])
      );
   end

   ctm_dist u_dist (
      .clock  (clock),
      .x_pos  (x_ff),
      .y_pos  (y_ff),
      .slot_x (head.x),
      .slot_y (head.y),
      .dist_sq(dist_sq)
   );

   // Any confirmed track still ahead in the report scan (cells hold the rest).
   always_comb begin
      rest_hit = 1'b0;
      for (int k = 0; k < N - 1; k++) begin
         if ({1'b0, pos_ff} + (CW + 1)'(k) + (CW + 1)'(1) < (CW + 1)'(N))
            rest_hit = rest_hit || (slots[k+1].used && slots[k+1].found >= min_found_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lost_ff <= 8'd1;
         max_dist_ff <= 12'd60;
         min_found_ff <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            ctm_pkg::CSR_MAX_LOST: max_lost_ff <= csr_wdata[7:0];
            ctm_pkg::CSR_MAX_DIST: max_dist_ff <= csr_wdata;
            ctm_pkg::CSR_MIN_FOUND: min_found_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Score position trails the ring by the distance pipeline (dx_ff, then dist_ff).
   assign score_pos = (SW + 1)'(cnt_ff - (CW + 1)'(2));

   always_comb begin
      state_in = state_ff;
      next_id_in = next_id_ff;
      ovf_in = ovf_ff;
      x_in = x_ff;
      y_in = y_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      best_in = best_ff;
      pick_in = pick_ff;
      free_in = free_ff;
      found_any_in = found_any_ff;
      rep_in = rep_ff;
      req_ready = 1'b0;
      ctl = '0;
      ctl.x = x_ff;
      ctl.y = y_ff;
      ctl.id = next_id_ff;
      ctl.lost_limit = max_lost_ff;
      ctl.found_cap = min_found_ff;
      case (state_ff)
         ctm_pkg::ST_IDLE: begin
            // The output register holds its own copy, so a waiting word does not block.
            req_ready = 1'b1;
            if (req_valid && req_ready) begin
               x_in = req_x_pos;
               y_in = req_y_pos;
               cnt_in = '0;
               pos_in = '0;
               best_in = {1'b0, radius_sq};
               pick_in = (SW + 1)'(N);
               free_in = (SW + 1)'(N);
               found_any_in = 1'b0;
               rep_in = '0;
               case (req_command)
                  ctm_pkg::CMD_DETECT: state_in = ctm_pkg::ST_SCAN;
                  ctm_pkg::CMD_EOF: state_in = ctm_pkg::ST_AGE;
                  ctm_pkg::CMD_RESET: begin
                     ctl.clear = 1'b1;
                     next_id_in = '0;
                     ovf_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ctm_pkg::ST_SCAN: begin
            // Rotate once around; head holds slot pos_ff this cycle.
            if (cnt_ff < (CW + 1)'(N)) begin
               ctl.rotate = 1'b1;
               pos_in = pos_ff + (SW + 1)'(1);
               if (!head.used && free_ff[SW]) free_in = pos_ff;
            end
            // dist_sq belongs to slot score_pos; its status rides in elig_pipe_ff
            if (cnt_ff >= (CW + 1)'(2) && elig_pipe_ff[1] && dist_sq < best_ff) begin
               best_in = dist_sq;
               pick_in = score_pos;
            end
            cnt_in = cnt_ff + (CW + 1)'(1);
            if (cnt_ff == (CW + 1)'(N + 1)) begin
               state_in = ctm_pkg::ST_COMMIT;
               cnt_in = '0;
               pos_in = '0;
            end
         end
         ctm_pkg::ST_COMMIT: begin
            // Rotate to the target slot and write it at the head.
            if (!pick_ff[SW] || !free_ff[SW]) begin
               if (pos_ff == (pick_ff[SW] ? free_ff : pick_ff)) begin
                  ctl.upd = !pick_ff[SW];
                  ctl.open = pick_ff[SW];
                  if (pick_ff[SW]) next_id_in = next_id_ff + 16'd1;
                  pick_in = (SW + 1)'(N);
                  free_in = (SW + 1)'(N);
               end
            end else if (pos_ff == '0 && cnt_ff == '0) begin
               ovf_in = 1'b1;
            end
            ctl.rotate = 1'b1;
            pos_in = pos_ff + (SW + 1)'(1);
            cnt_in = cnt_ff + (CW + 1)'(1);
            if (cnt_ff == (CW + 1)'(N - 1)) state_in = ctm_pkg::ST_IDLE;
         end
         ctm_pkg::ST_AGE: begin
            ctl.age = 1'b1;
            ctl.rotate = 1'b1;
            cnt_in = cnt_ff + (CW + 1)'(1);
            if (cnt_ff == (CW + 1)'(N - 1)) begin
               state_in = ctm_pkg::ST_REPORT;
               cnt_in = '0;
               pos_in = '0;
            end
         end
         ctm_pkg::ST_REPORT: begin
            // Walk the ring; head cell shows slot pos_ff.
            if (out_free) begin
               if (report_hit) found_any_in = 1'b1;
               if (report_hit && rep_ff != CW'(N)) rep_in = rep_ff + CW'(1);
               ctl.rotate = 1'b1;
               pos_in = pos_ff + (SW + 1)'(1);
               if (pos_ff == (SW + 1)'(N - 1)) begin
                  state_in = (found_any_ff || report_hit) ? ctm_pkg::ST_IDLE
                                                          : ctm_pkg::ST_EMPTY;
                  if (found_any_ff || report_hit) ovf_in = 1'b0;
               end
            end
         end
         ctm_pkg::ST_EMPTY: begin
            if (out_free) begin
               ovf_in = 1'b0;
               state_in = ctm_pkg::ST_IDLE;
            end
         end
         default: state_in = ctm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctm_pkg::ST_IDLE;
         next_id_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         pos_ff <= '0;
         rep_ff <= '0;
         found_any_ff <= 1'b0;
         elig_pipe_ff <= '0;
      end else begin
         state_ff <= state_in;
         next_id_ff <= next_id_in;
         ovf_ff <= ovf_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         rep_ff <= rep_in;
         found_any_ff <= found_any_in;
         elig_pipe_ff <= {elig_pipe_ff[0], elig_now};
         rsp_valid_ff <= (load_hit && rep_ff != CW'(N)) || load_empty ||
                         (rsp_valid_ff && !rsp_ready);
      end
      best_ff <= best_in;
      pick_ff <= pick_in;
      free_ff <= free_in;
      x_ff <= x_in;
      y_ff <= y_in;
      if (load_hit) begin
         out_ff <= report_slot;
         out_has_ff <= 1'b1;
         out_ovf_ff <= ovf_ff;
         out_last_ff <= !rest_hit || (rep_ff == CW'(N - 1));
      end
      if (load_empty) begin
         out_ff <= '0;
         out_has_ff <= 1'b0;
         out_ovf_ff <= ovf_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_has_track = out_has_ff;
   assign rsp_track_id = out_ff.id;
   assign rsp_track_x = out_ff.x;
   assign rsp_track_y = out_ff.y;
   assign rsp_lost_count = out_ff.lost;
   assign rsp_found_count = out_ff.found;
   assign rsp_table_overflow = out_ovf_ff;
   assign rsp_last = out_last_ff;

   `CTM_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ctm_pkg::ST_IDLE)
   `CTM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_ff))
   `CTM_ASSERT_NEXT(a_clear, clock, reset, req_valid && req_ready && req_command == ctm_pkg::CMD_RESET, next_id_ff == '0 && !ovf_ff)
endmodule
`default_nettype wire

FILE: tb/sv/tb_centroid_track_matcher_top.sv
`default_nettype none
module tb_centroid_track_matcher_top;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SettleCycles = 80;

   typedef struct packed {
      logic        has_track;
      logic [15:0] track_id;
      logic [11:0] track_x;
      logic [11:0] track_y;
      logic [7:0]  lost_count;
      logic [7:0]  found_count;
      logic        table_overflow;
      logic        last;
   } track_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = ctm_pkg::CMD_DETECT;
   logic [11:0] req_x_pos = '0;
   logic [11:0] req_y_pos = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_has_track;
   logic [15:0] rsp_track_id;
   logic [11:0] rsp_track_x;
   logic [11:0] rsp_track_y;
   logic [7:0]  rsp_lost_count;
   logic [7:0]  rsp_found_count;
   logic        rsp_table_overflow;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = ctm_pkg::CSR_MAX_LOST;
   logic [11:0] csr_wdata = '0;

   // tracker image kept by the testbench
   ctm_pkg::slot_type track_table[ctm_pkg::MaxTracks];
   logic [15:0] next_id;
   logic        refused_flag;
   logic [7:0]  lost_limit;
   logic [11:0] match_radius;
   logic [7:0]  confirm_count;

   track_report_type pending_reports[$];
   int error_count = 0;
   int words_sent = 0;
   int reports_checked = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   centroid_track_matcher_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("track report with none pending");
         end else begin
            track_report_type want;
            want = pending_reports.pop_front();
            check_field("has_track", 32'(rsp_has_track), 32'(want.has_track));
            check_field("track_id", 32'(rsp_track_id), 32'(want.track_id));
            check_field("track_x", 32'(rsp_track_x), 32'(want.track_x));
            check_field("track_y", 32'(rsp_track_y), 32'(want.track_y));
            check_field("lost_count", 32'(rsp_lost_count), 32'(want.lost_count));
            check_field("found_count", 32'(rsp_found_count), 32'(want.found_count));
            check_field("table_overflow", 32'(rsp_table_overflow),
                        32'(want.table_overflow));
            check_field("last", 32'(rsp_last), 32'(want.last));
         end
         reports_checked++;
      end
   end

   function automatic void clear_tracks();
      for (int i = 0; i < ctm_pkg::MaxTracks; i++) track_table[i] = '0;
      next_id = '0;
      refused_flag = 1'b0;
   endfunction

   function automatic void match_detection(input logic [11:0] x, input logic [11:0] y);
      longint best;
      longint d2;
      longint dx;
      longint dy;
      int pick;
      int f;
      best = longint'(match_radius) * longint'(match_radius);
      pick = -1;
      for (int i = 0; i < ctm_pkg::MaxTracks; i++) begin
         if (!track_table[i].used || track_table[i].fresh || track_table[i].matched) continue;
         dx = longint'(x) - longint'(track_table[i].x);
         dy = longint'(y) - longint'(track_table[i].y);
         d2 = dx * dx + dy * dy;
         if (d2 < best) begin
            best = d2;
            pick = i;
         end
      end
      if (pick >= 0) begin
         f = int'(track_table[pick].found) + 1;
         track_table[pick].x = x;
         track_table[pick].y = y;
         track_table[pick].lost = '0;
         track_table[pick].found = (f < int'(confirm_count)) ? 8'(f) : confirm_count;
         track_table[pick].matched = 1'b1;
         return;
      end
      for (int i = 0; i < ctm_pkg::MaxTracks; i++) begin
         if (!track_table[i].used) begin
            track_table[i] = '0;
            track_table[i].used = 1'b1;
            track_table[i].fresh = 1'b1;
            track_table[i].id = next_id;
            track_table[i].x = x;
            track_table[i].y = y;
            next_id = next_id + 16'd1;
            return;
         end
      end
      refused_flag = 1'b1;
   endfunction

   function automatic void close_frame();
      track_report_type frame_reports[$];
      track_report_type r;
      int l;
      for (int i = 0; i < ctm_pkg::MaxTracks; i++) begin
         if (!track_table[i].used) continue;
         if (!track_table[i].fresh && !track_table[i].matched) begin
            l = int'(track_table[i].lost) + 1;
            if (l >= int'(lost_limit)) track_table[i].used = 1'b0;
            else track_table[i].lost = 8'(l);
         end
         track_table[i].fresh = 1'b0;
         track_table[i].matched = 1'b0;
      end
      for (int i = 0; i < ctm_pkg::MaxTracks; i++) begin
         if (!track_table[i].used || track_table[i].found < confirm_count) continue;
         r = '0;
         r.has_track = 1'b1;
         r.track_id = track_table[i].id;
         r.track_x = track_table[i].x;
         r.track_y = track_table[i].y;
         r.lost_count = track_table[i].lost;
         r.found_count = track_table[i].found;
         r.table_overflow = refused_flag;
         frame_reports = {frame_reports, r};
      end
      if (frame_reports.size() == 0) begin
         r = '0;
         r.table_overflow = refused_flag;
         frame_reports = {frame_reports, r};
      end
      frame_reports[frame_reports.size() - 1].last = 1'b1;
      pending_reports = {pending_reports, frame_reports};
      refused_flag = 1'b0;
   endfunction

   // Called just after a rising edge; leaves valid high on return.
   task automatic send_word(input logic [1:0] cmd, input logic [11:0] x, input logic [11:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_x_pos <= x;
      req_y_pos <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      case (cmd)
         ctm_pkg::CMD_DETECT: match_detection(x, y);
         ctm_pkg::CMD_EOF: close_frame();
         ctm_pkg::CMD_RESET: clear_tracks();
         default: ;
      endcase
   endtask

   // Hold off until every pending report is out and the block has settled.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_regs(input logic [7:0] lost, input logic [11:0] radius,
                             input logic [7:0] found);
      csr_we <= 1'b1;
      csr_index <= ctm_pkg::CSR_MAX_LOST;
      csr_wdata <= {4'd0, lost};
      @(posedge clock);
      csr_index <= ctm_pkg::CSR_MAX_DIST;
      csr_wdata <= radius;
      @(posedge clock);
      csr_index <= ctm_pkg::CSR_MIN_FOUND;
      csr_wdata <= {4'd0, found};
      @(posedge clock);
      csr_we <= 1'b0;
      lost_limit = lost;
      match_radius = radius;
      confirm_count = found;
      @(posedge clock);
   endtask

   task automatic test_defaults_and_ties();
      send_word(ctm_pkg::CMD_DETECT, 12'd0, 12'd0);
      send_word(ctm_pkg::CMD_DETECT, 12'd4095, 12'd4095);
      send_word(ctm_pkg::CMD_DETECT, 12'd100, 12'd100);
      send_word(ctm_pkg::CMD_DETECT, 12'd120, 12'd100);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      // equidistant from two old tracks: lower slot takes it
      send_word(ctm_pkg::CMD_DETECT, 12'd110, 12'd100);
      send_word(ctm_pkg::CMD_DETECT, 12'd4090, 12'd4095);
      send_word(ctm_pkg::CMD_DETECT, 12'd3, 12'd2);
      send_word(CMD_UNUSED, 12'hfff, 12'hfff);
      send_word(ctm_pkg::CMD_EOF, 12'hfff, 12'hfff);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      send_word(ctm_pkg::CMD_RESET, 12'd0, 12'd0);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      // zero lost limit and zero radius: nothing matches, a track is dropped at its first aging after the opening frame
      write_regs(8'd0, 12'd0, 8'd0);
      send_word(ctm_pkg::CMD_DETECT, 12'd5, 12'd5);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      send_word(ctm_pkg::CMD_DETECT, 12'd5, 12'd5);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      wait_drained();
      write_regs(8'd255, 12'd4095, 8'd255);
      send_word(ctm_pkg::CMD_RESET, 12'd0, 12'd0);
      for (int i = 0; i < ctm_pkg::MaxTracks + 2; i++)
         send_word(ctm_pkg::CMD_DETECT, 12'($urandom_range(4095)),
                   12'($urandom_range(4095)));
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      wait_drained();
      write_regs(8'd1, 12'd1, 8'd1);
      send_word(ctm_pkg::CMD_DETECT, 12'd2000, 12'd2000);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      send_word(ctm_pkg::CMD_DETECT, 12'd2000, 12'd2000);
      send_word(ctm_pkg::CMD_EOF, 12'd0, 12'd0);
      wait_drained();
   endtask

   function automatic logic [11:0] near(input logic [11:0] base, input int spread);
      int v;
      v = int'(base) + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   task automatic send_random_frame();
      int n;
      int spread;
      int pick;
      n = ($urandom_range(9) == 0) ?
          $urandom_range(ctm_pkg::MaxTracks + 4, ctm_pkg::MaxTracks) : $urandom_range(6);
      spread = int'(match_radius) / 2 + 1;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(ctm_pkg::MaxTracks - 1);
         if ($urandom_range(3) != 0 && track_table[pick].used)
            send_word(ctm_pkg::CMD_DETECT, near(track_table[pick].x, spread),
                      near(track_table[pick].y, spread));
         else
            send_word(ctm_pkg::CMD_DETECT, 12'($urandom_range(4095)),
                      12'($urandom_range(4095)));
      end
      case ($urandom_range(19))
         0: send_word(ctm_pkg::CMD_RESET, 12'($urandom_range(4095)),
                      12'($urandom_range(4095)));
         1: send_word(CMD_UNUSED, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
         default: ;
      endcase
      send_word(ctm_pkg::CMD_EOF, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
   endtask

   task automatic test_random_frames(input int word_goal, input int tx_idle, input int rx_idle);
      int stop_at;
      bit paused;
      send_idle_pct = tx_idle;
      recv_idle_pct = rx_idle;
      write_regs(8'($urandom_range(6, 1)), 12'($urandom_range(300, 5)),
                 8'($urandom_range(4)));
      stop_at = words_sent + word_goal;
      paused = 0;
      while (words_sent < stop_at) begin
         send_random_frame();
         if (!paused && words_sent > stop_at - word_goal / 2) begin
            paused = 1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_reports.size() != 0) @(posedge clock);
         end
      end
      wait_drained();
   endtask

   initial begin
      lost_limit = 8'd1;
      match_radius = 12'd60;
      confirm_count = 8'd1;
      clear_tracks();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults_and_ties();
      test_register_extremes();
      test_random_frames(70, 29, 51);
      test_random_frames(70, 51, 29);
      test_random_frames(70, 0, 0);
      $display("Sent %0d words and checked %0d track reports", words_sent, reports_checked);
      $display("Covered matching, ties, aging, full table, register extremes and resets");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout with %0d reports pending", pending_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/ctm_pkg.sv
sv/ctm_cell.sv
sv/ctm_dist.sv
sv/centroid_track_matcher_top.sv
tb/sv/tb_centroid_track_matcher_top.sv
